[src/dfs_pkg.sv]
`timescale 1ns / 1ps
package dfs_pkg;
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_TOTAL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_RUN_INIT,
    ST_RUN_HEAD,
    ST_FRAME_RD,
    ST_EDGE_RD,
    ST_EDGE_EVAL,
    ST_PUSH,
    ST_REV_HEAD,
    ST_TOTAL
  } state_t;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned MAX_RESULTS = 64;
  localparam logic [21:0] COST_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [15:0] edge_cost;
    logic [5:0]  start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  edge_index;
    logic [15:0] tree_edge_cost;
    logic [21:0] total_cost;
    logic        last;
  } out_item_t;
endpackage

[src/dfs_spanning_tree_cost_unit.sv]
`timescale 1ns / 1ps
// Per item: add edge reads both head tables, then writes the edge record and both heads; clear
// sweeps every head-table entry; an error result appears in the cycle after acceptance.
// Run: walks the forward then the reverse list of each vertex depth first, then gives the total.
// One item at a time; busy is already low when the last result is out.
// Reset: synchronous active low; sweeps all MAX_VERTICES entries to empty the head tables.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module dfs_spanning_tree_cost_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dfs_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  output logic                out_valid,
  output dfs_pkg::out_item_t  out_item
);
  import dfs_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int RW = $clog2(MAX_RESULTS);
  localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

  // edge record: next pointers, endpoints, weight
  typedef struct packed {
    logic [EW-1:0] fnext;
    logic [EW-1:0] rnext;
    logic [5:0]    from_v;
    logic [5:0]    to_v;
    logic [15:0]   weight;
  } edge_rec_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          phase;
    logic [EW-1:0] cursor;
  } frame_t;

  logic [EW-1:0] fhead_mem [MAX_VERTICES];
  logic [EW-1:0] rhead_mem [MAX_VERTICES];
  edge_rec_t     edge_mem  [MAX_EDGES];
  frame_t        stk_mem   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;

  state_t state_r, state_nxt;
  logic [6:0] vcount_r;
  logic [EW-1:0] loaded_r, loaded_nxt;
  logic [VW:0] sweep_r, sweep_nxt;
  in_item_t item_r, item_nxt;
  logic [21:0] sum_r, sum_nxt;
  logic [RW:0] count_r, count_nxt;
  logic [VW:0] depth_r, depth_nxt;
  frame_t top_r, top_nxt;
  logic [VW-1:0] other_r, other_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // memory ports
  logic [VW-1:0] h_addr;
  logic [VW-1:0] hr_waddr;
  logic h_we_f, h_we_r;
  logic [EW-1:0] h_wf, h_wr, fhead_q, rhead_q;
  logic [EW-1:0] e_raddr, e_waddr;
  logic e_we;
  edge_rec_t e_wdata, edge_q;
  logic [VW-1:0] s_addr;
  logic s_we;
  frame_t s_wdata, stk_q;

  always_ff @(posedge clk) begin
    if (h_we_f) fhead_mem[h_addr] <= h_wf;
    if (h_we_r) rhead_mem[hr_waddr] <= h_wr;
    fhead_q <= fhead_mem[h_addr];
    rhead_q <= rhead_mem[h_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_waddr[EW-2:0]] <= e_wdata;
    edge_q <= edge_mem[e_raddr[EW-2:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_addr] <= s_wdata;
    stk_q <= stk_mem[s_addr];
  end

  logic [6:0] n_used;
  always_comb begin
    if (vcount_r == 7'd0) n_used = 7'd1;
    else if ({25'd0, vcount_r} > MAX_VERTICES) n_used = 7'(MAX_VERTICES);
    else n_used = vcount_r;
  end

  logic [21:0] sum_add;
  logic [22:0] sum_wide;
  assign sum_wide = {1'b0, sum_r} + 23'(edge_q.weight);
  assign sum_add  = sum_wide[22] ? COST_MAX : sum_wide[21:0];

  logic [5:0] other_v;
  logic cur_valid;
  always_comb begin
    if (!top_r.phase)
      other_v = (edge_q.to_v == 6'(top_r.vertex)) ? edge_q.from_v : edge_q.to_v;
    else
      other_v = (edge_q.from_v == 6'(top_r.vertex)) ? edge_q.to_v : edge_q.from_v;
    cur_valid = (top_r.cursor < NIL) && (top_r.cursor < loaded_r);
  end

  assign busy = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_item.cmd))
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_ADD: begin
              if ({1'b0, in_item.from_vertex} < n_used && {1'b0, in_item.to_vertex} < n_used
                  && loaded_r < NIL)
                state_nxt = ST_ADD_RD;
            end
            CMD_RUN: begin
              if ({1'b0, in_item.start_vertex} < n_used) state_nxt = ST_RUN_INIT;
            end
            CMD_NONE: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (sweep_r == (VW+1)'(MAX_VERTICES - 1)) state_nxt = ST_IDLE;
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_RUN_INIT: state_nxt = ST_RUN_HEAD;
      ST_RUN_HEAD: state_nxt = ST_EDGE_RD;
      ST_FRAME_RD: state_nxt = ST_EDGE_RD;
      ST_EDGE_RD: begin
        priority if (cur_valid) state_nxt = ST_EDGE_EVAL;
        else if (!top_r.phase) state_nxt = ST_REV_HEAD;
        else if (depth_r == (VW+1)'(1)) state_nxt = ST_TOTAL;
        else state_nxt = ST_FRAME_RD;
      end
      ST_EDGE_EVAL: begin
        priority if (visited_r[other_v[VW-1:0]] || {26'd0, other_v} >= MAX_VERTICES)
          state_nxt = ST_EDGE_RD;
        else state_nxt = ST_PUSH;
      end
      ST_PUSH: state_nxt = ST_EDGE_RD;
      ST_REV_HEAD: state_nxt = ST_EDGE_RD;
      ST_TOTAL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    loaded_nxt = loaded_r;
    sweep_nxt = sweep_r;
    item_nxt = item_r;
    sum_nxt = sum_r;
    count_nxt = count_r;
    depth_nxt = depth_r;
    top_nxt = top_r;
    other_nxt = other_r;
    visited_nxt = visited_r;
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    h_addr = '0;
    hr_waddr = '0;
    h_we_f = 1'b0;
    h_we_r = 1'b0;
    h_wf = NIL;
    h_wr = NIL;
    e_raddr = top_r.cursor;
    e_waddr = loaded_r;
    e_we = 1'b0;
    e_wdata = '0;
    s_addr = depth_r[VW-1:0] - VW'(1);
    s_we = 1'b0;
    s_wdata = top_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          h_addr = in_item.from_vertex[VW-1:0];
          unique case (cmd_t'(in_item.cmd))
            CMD_CLEAR: begin
              sweep_nxt = '0;
              loaded_nxt = '0;
              sum_nxt = '0;
              visited_nxt = '0;
            end
            CMD_ADD: begin
              if (!({1'b0, in_item.from_vertex} < n_used && {1'b0, in_item.to_vertex} < n_used
                  && loaded_r < NIL)) begin
                out_valid_nxt = 1'b1;
                out_nxt.kind = KIND_ERROR;
                out_nxt.last = 1'b1;
              end
            end
            CMD_RUN: begin
              h_addr = in_item.start_vertex[VW-1:0];
              if (!({1'b0, in_item.start_vertex} < n_used)) begin
                out_valid_nxt = 1'b1;
                out_nxt.kind = KIND_ERROR;
                out_nxt.last = 1'b1;
              end
            end
            CMD_NONE: ;
          endcase
        end
      end
      ST_CLEAR: begin
        h_addr = sweep_r[VW-1:0];
        hr_waddr = sweep_r[VW-1:0];
        h_we_f = 1'b1;
        h_we_r = 1'b1;
        sweep_nxt = sweep_r + (VW+1)'(1);
      end
      ST_ADD_RD: begin
        // forward head read is out; fetch reverse head next
        h_addr = item_r.to_vertex[VW-1:0];
        other_nxt = VW'(0);
        top_nxt.cursor = fhead_q;
      end
      ST_ADD_WR: begin
        e_we = 1'b1;
        e_wdata.fnext = top_r.cursor;
        e_wdata.rnext = rhead_q;
        e_wdata.from_v = item_r.from_vertex;
        e_wdata.to_v = item_r.to_vertex;
        e_wdata.weight = item_r.edge_cost;
        h_addr = item_r.from_vertex[VW-1:0];
        h_we_f = 1'b1;
        h_wf = loaded_r;
        hr_waddr = item_r.to_vertex[VW-1:0];
        h_we_r = 1'b1;
        h_wr = loaded_r;
        loaded_nxt = loaded_r + EW'(1);
      end
      ST_RUN_INIT: begin
        visited_nxt = '0;
        visited_nxt[item_r.start_vertex[VW-1:0]] = 1'b1;
        sum_nxt = '0;
        count_nxt = '0;
        depth_nxt = (VW+1)'(1);
        top_nxt.vertex = item_r.start_vertex[VW-1:0];
        top_nxt.phase = 1'b0;
        top_nxt.cursor = fhead_q;
      end
      ST_RUN_HEAD: begin
        e_raddr = top_r.cursor;
      end
      ST_FRAME_RD: begin
        top_nxt = stk_q;
        e_raddr = stk_q.cursor;
      end
      ST_EDGE_RD: begin
        if (!cur_valid) begin
          if (!top_r.phase) begin
            h_addr = top_r.vertex;
          end else begin
            depth_nxt = depth_r - (VW+1)'(1);
            s_addr = depth_r[VW-1:0] - VW'(2);
          end
        end
      end
      ST_EDGE_EVAL: begin
        top_nxt.cursor = top_r.phase ? edge_q.rnext : edge_q.fnext;
        other_nxt = other_v[VW-1:0];
        h_addr = other_v[VW-1:0];
        if (!(visited_r[other_v[VW-1:0]] || {26'd0, other_v} >= MAX_VERTICES)) begin
          visited_nxt[other_v[VW-1:0]] = 1'b1;
          if (count_r < (RW+1)'(MAX_RESULTS - 1)) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind = KIND_EDGE;
            out_nxt.edge_index = 8'(top_r.cursor);
            out_nxt.tree_edge_cost = edge_q.weight;
            count_nxt = count_r + (RW+1)'(1);
          end
          sum_nxt = sum_add;
        end else begin
          e_raddr = top_r.phase ? edge_q.rnext : edge_q.fnext;
        end
      end
      ST_PUSH: begin
        if ({{(31-VW){1'b0}}, depth_r} < MAX_VERTICES) begin
          // save the current frame, descend into the new vertex
          s_we = 1'b1;
          s_wdata = top_r;
          top_nxt.vertex = other_r;
          top_nxt.phase = 1'b0;
          top_nxt.cursor = fhead_q;
          depth_nxt = depth_r + (VW+1)'(1);
          e_raddr = fhead_q;
        end
      end
      ST_REV_HEAD: begin
        top_nxt.phase = 1'b1;
        top_nxt.cursor = rhead_q;
        e_raddr = rhead_q;
      end
      ST_TOTAL: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind = KIND_TOTAL;
        out_nxt.total_cost = sum_r;
        out_nxt.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      vcount_r <= 7'd64;
      loaded_r <= '0;
      sweep_r <= '0;
      sum_r <= '0;
      count_r <= '0;
      depth_r <= '0;
      visited_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_wdata;
      loaded_r <= loaded_nxt;
      sweep_r <= sweep_nxt;
      sum_r <= sum_nxt;
      count_r <= count_nxt;
      depth_r <= depth_nxt;
      visited_r <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    top_r <= top_nxt;
    other_r <= other_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;
endmodule

[src/dfs_checker.sv]
`timescale 1ns / 1ps
module dfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input dfs_pkg::out_item_t out_item
);
  import dfs_pkg::*;

  // a total item always closes the command
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_TOTAL |-> out_item.last) else $error("total not last");

  // tree edges never carry last
  a_edge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_EDGE |-> !out_item.last) else $error("edge marked last");

  // block is idle while a last result is out
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy) else $error("busy after last");

  // only tree edges come out while the block is busy
  a_busy_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy |-> out_item.kind == KIND_EDGE) else $error("non-edge while busy");
endmodule

bind dfs_spanning_tree_cost_unit dfs_checker u_dfs_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
